>>> rtl/nptc_pkg.sv
package nptc_pkg;

	localparam int COORD_W  = 32;
	localparam int COLOUR_W = 16;
	localparam int WIDE_W   = COORD_W + 1;
	localparam int TDATA_W  = 3 * COORD_W + 3 * COLOUR_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LDA,
		S_LDB,
		S_DIV,
		S_LERP,
		S_EMIT
	} state_t;

	typedef enum logic [2:0] {
		SRC_V0,
		SRC_V1,
		SRC_V2,
		SRC_PA,
		SRC_PB
	} src_t;

	typedef enum logic [2:0] {
		CC_NONE,
		CC_B01,
		CC_B02,
		CC_B12,
		CC_B0,
		CC_B1,
		CC_B2
	} clip_case_t;

	function automatic src_t vidx_src(input logic [1:0] idx);
		unique case (idx)
			2'd0:    return SRC_V0;
			2'd1:    return SRC_V1;
			default: return SRC_V2;
		endcase
	endfunction

	// emission order of each case, up to six vertices
	function automatic src_t seq_src(input clip_case_t cc, input logic [2:0] k);
		src_t far_v;
		src_t alt_v;
		far_v = SRC_V2;
		alt_v = SRC_V1;
		unique case (cc)
			CC_B0:   begin far_v = SRC_V2; alt_v = SRC_V1; end
			CC_B1:   begin far_v = SRC_V2; alt_v = SRC_V0; end
			CC_B2:   begin far_v = SRC_V1; alt_v = SRC_V0; end
			CC_B01:  far_v = SRC_V2;
			CC_B02:  far_v = SRC_V1;
			CC_B12:  far_v = SRC_V0;
			default: far_v = SRC_V2;
		endcase
		if (cc == CC_NONE) begin
			return vidx_src(k[1:0]);
		end
		if (cc == CC_B01 || cc == CC_B02 || cc == CC_B12) begin
			unique case (k)
				3'd0:    return SRC_PA;
				3'd1:    return far_v;
				default: return SRC_PB;
			endcase
		end
		unique case (k)
			3'd0:    return SRC_PA;
			3'd1:    return SRC_PB;
			3'd2:    return far_v;
			3'd3:    return alt_v;
			3'd4:    return SRC_PA;
			default: return far_v;
		endcase
	endfunction

	function automatic logic [2:0] seq_len(input clip_case_t cc);
		unique case (cc)
			CC_B0, CC_B1, CC_B2: return 3'd6;
			default:             return 3'd3;
		endcase
	endfunction

	// behind vertex of cut sel (0 = PA, 1 = PB)
	function automatic logic [1:0] cut_a(input clip_case_t cc, input logic sel);
		unique case (cc)
			CC_B01:  return sel ? 2'd1 : 2'd0;
			CC_B02:  return sel ? 2'd2 : 2'd0;
			CC_B12:  return sel ? 2'd2 : 2'd1;
			CC_B0:   return 2'd0;
			CC_B1:   return 2'd1;
			default: return 2'd2;
		endcase
	endfunction

	function automatic logic [1:0] cut_b(input clip_case_t cc, input logic sel);
		unique case (cc)
			CC_B01:  return 2'd2;
			CC_B02:  return 2'd1;
			CC_B12:  return 2'd0;
			CC_B0:   return sel ? 2'd2 : 2'd1;
			CC_B1:   return sel ? 2'd2 : 2'd0;
			default: return sel ? 2'd1 : 2'd0;
		endcase
	endfunction

endpackage

>>> rtl/nptc_div.sv
module nptc_div #(
	parameter int QW = 17
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [nptc_pkg::WIDE_W-1:0]  num,
	input  logic [nptc_pkg::WIDE_W-1:0]  den,
	output logic                         done,
	output logic [QW-1:0]                quot
);
	import nptc_pkg::*;

	localparam int CW = $clog2(QW + 1);

	logic [WIDE_W:0]   rem_q;
	logic [WIDE_W-1:0] den_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic [QW-1:0]     quot_q;
	logic [WIDE_W+1:0] diff;
	logic              qbit;
	logic [WIDE_W:0]   rem_nx;

	assign diff   = {1'b0, rem_q} - {2'b00, den_q};
	assign qbit   = !diff[WIDE_W+1];
	assign rem_nx = qbit ? diff[WIDE_W:0] : rem_q;
	assign done   = busy_q && (cnt_q == '0);
	assign quot   = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(QW);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			rem_q  <= {rem_nx[WIDE_W-1:0], 1'b0};
			quot_q <= {quot_q[QW-2:0], qbit};
		end
	end

endmodule

>>> rtl/nptc_lerp.sv
module nptc_lerp #(
	parameter int FB = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                issue,
	input  logic signed [nptc_pkg::WIDE_W-1:0]  a,
	input  logic signed [nptc_pkg::WIDE_W-1:0]  b,
	input  logic [FB:0]                         ratio,
	output logic                                res_vld,
	output logic signed [nptc_pkg::WIDE_W-1:0]  res
);
	import nptc_pkg::*;

	localparam int PW = WIDE_W + FB + 2;

	logic signed [WIDE_W:0]   d;
	logic [WIDE_W:0]          mag;
	logic                     vld_s1;
	logic                     neg_s1;
	logic signed [WIDE_W-1:0] a_s1;
	logic [PW-1:0]            prod_s1;
	logic [WIDE_W-1:0]        part;
	logic                     vld_s2;
	logic signed [WIDE_W-1:0] res_s2;

	assign d    = {b[WIDE_W-1], b} - {a[WIDE_W-1], a};
	assign mag  = d[WIDE_W] ? (~d + 1'b1) : d;
	assign part = prod_s1[FB +: WIDE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PW'(mag) * PW'(ratio);
		neg_s1  <= d[WIDE_W];
		a_s1    <= a;
		res_s2  <= neg_s1 ? a_s1 - $signed(part) : a_s1 + $signed(part);
	end

	assign res_vld = vld_s2;
	assign res     = res_s2;

endmodule

>>> rtl/near_plane_triangle_clipper_unit.sv
// Near-plane triangle clipper. Send the three vertices of a triangle as three
// input beats (x, y, z, red, green, blue); after the third, the block takes no
// beat until the triangle is finished. It then emits 0, 3 or 6 vertex beats,
// tuser giving the corner within each output triangle and tlast marking the
// final vertex of the input triangle. A triangle with no vertex behind the
// plane goes straight to emission after its third beat. Each clipped edge is
// cut by one shared restoring divider and one shared multiplier that works
// through five channels in turn, after the operands of both end vertices are
// loaded. Once both cuts are done, a clipped triangle emits one beat per cycle
// while the output is not stalled by m_axis_tready.
// near_plane is sampled with the third vertex.
module near_plane_triangle_clipper_unit #(
	parameter int COORD_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [31:0]                   cfg_wr_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// pos_x, pos_y, pos_z, red, green, blue
	input  logic [nptc_pkg::TDATA_W-1:0]  s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// out_x, out_y, out_z, out_red, out_green, out_blue
	output logic [nptc_pkg::TDATA_W-1:0]  m_axis_tdata,
	// corner
	output logic [1:0]                    m_axis_tuser,
	output logic                          m_axis_tlast
);
	import nptc_pkg::*;

	localparam int QW = COORD_FRAC_BITS + 1;

	state_t     state_q, state_nx;
	clip_case_t case_q;
	logic [31:0] near_q, near_s_q;
	logic [1:0]  vcnt_q;

	logic [COORD_W-1:0]  vx_q [3];
	logic [COORD_W-1:0]  vy_q [3];
	logic [COORD_W-1:0]  vz_q [3];
	logic [COLOUR_W-1:0] vr_q [3];
	logic [COLOUR_W-1:0] vg_q [3];
	logic [COLOUR_W-1:0] vb_q [3];

	logic signed [WIDE_W-1:0] a_q [5];
	logic signed [WIDE_W-1:0] b_q [5];
	logic [COORD_W-1:0] a_z_q;
	logic [COORD_W-1:0] cx_q [2];
	logic [COORD_W-1:0] cy_q [2];
	logic [COLOUR_W-1:0] cr_q [2];
	logic [COLOUR_W-1:0] cg_q [2];
	logic [COLOUR_W-1:0] cb_q [2];

	logic        sel_q;
	logic [2:0]  iss_q, got_q, k_q;
	logic        out_vld_q;
	logic [TDATA_W-1:0] out_data_q;
	logic [1:0]  out_corner_q;
	logic        out_last_q;

	logic        in_fire, slot_free, div_start, div_done, lerp_vld;
	logic [QW-1:0] ratio;
	logic signed [WIDE_W-1:0] lerp_res;
	logic [1:0]  rd_idx;
	src_t        src;
	logic        b0, b1, b2;
	clip_case_t  case_nx;
	logic [WIDE_W-1:0] div_num, div_den;
	logic [COORD_W-1:0]  rx, ry, rz;
	logic [COLOUR_W-1:0] rr, rg, rb;
	logic [COORD_W-1:0]  ex, ey, ez;
	logic [COLOUR_W-1:0] er, eg, eb;
	logic [COORD_W-1:0]  in_x, in_y, in_z;
	logic [COLOUR_W-1:0] in_r, in_g, in_b;

	assign in_x = s_axis_tdata[0 +: COORD_W];
	assign in_y = s_axis_tdata[COORD_W +: COORD_W];
	assign in_z = s_axis_tdata[2*COORD_W +: COORD_W];
	assign in_r = s_axis_tdata[3*COORD_W +: COLOUR_W];
	assign in_g = s_axis_tdata[3*COORD_W+COLOUR_W +: COLOUR_W];
	assign in_b = s_axis_tdata[3*COORD_W+2*COLOUR_W +: COLOUR_W];

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign slot_free     = !out_vld_q || m_axis_tready;
	assign src           = seq_src(case_q, k_q);

	assign b0 = $signed(vz_q[0]) < $signed(near_q);
	assign b1 = $signed(vz_q[1]) < $signed(near_q);
	assign b2 = $signed(in_z) < $signed(near_q);

	always_comb begin
		unique case ({b2, b1, b0})
			3'b011:  case_nx = CC_B01;
			3'b101:  case_nx = CC_B02;
			3'b110:  case_nx = CC_B12;
			3'b001:  case_nx = CC_B0;
			3'b010:  case_nx = CC_B1;
			3'b100:  case_nx = CC_B2;
			default: case_nx = CC_NONE;
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_LDA:   rd_idx = cut_a(case_q, sel_q);
			S_LDB:   rd_idx = cut_b(case_q, sel_q);
			default: rd_idx = (src == SRC_V0) ? 2'd0 : (src == SRC_V1) ? 2'd1 : 2'd2;
		endcase
	end

	always_comb begin
		rx = vx_q[0]; ry = vy_q[0]; rz = vz_q[0];
		rr = vr_q[0]; rg = vg_q[0]; rb = vb_q[0];
		unique case (rd_idx)
			2'd1: begin
				rx = vx_q[1]; ry = vy_q[1]; rz = vz_q[1];
				rr = vr_q[1]; rg = vg_q[1]; rb = vb_q[1];
			end
			2'd2: begin
				rx = vx_q[2]; ry = vy_q[2]; rz = vz_q[2];
				rr = vr_q[2]; rg = vg_q[2]; rb = vb_q[2];
			end
			default: ;
		endcase
	end

	assign div_start = (state_q == S_LDB);
	assign div_num   = {near_s_q[31], near_s_q} - {a_z_q[31], a_z_q};
	assign div_den   = {rz[31], rz} - {a_z_q[31], a_z_q};

	nptc_div #(.QW(QW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (ratio)
	);

	nptc_lerp #(.FB(COORD_FRAC_BITS)) u_lerp (
		.clk     (clk),
		.arst_n  (arst_n),
		.issue   (state_q == S_LERP && iss_q < 3'd5),
		.a       (a_q[iss_q < 3'd5 ? iss_q : 3'd0]),
		.b       (b_q[iss_q < 3'd5 ? iss_q : 3'd0]),
		.ratio   (ratio),
		.res_vld (lerp_vld),
		.res     (lerp_res)
	);

	always_comb begin
		ex = rx; ey = ry; ez = rz; er = rr; eg = rg; eb = rb;
		if (src == SRC_PA || src == SRC_PB) begin
			ex = cx_q[src == SRC_PB];
			ey = cy_q[src == SRC_PB];
			ez = near_s_q;
			er = cr_q[src == SRC_PB];
			eg = cg_q[src == SRC_PB];
			eb = cb_q[src == SRC_PB];
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && vcnt_q == 2'd2) begin
					if (b0 && b1 && b2) begin
						state_nx = S_IDLE;
					end else if (case_nx == CC_NONE) begin
						state_nx = S_EMIT;
					end else begin
						state_nx = S_LDA;
					end
				end
			end
			S_LDA:  state_nx = S_LDB;
			S_LDB:  state_nx = S_DIV;
			S_DIV:  if (div_done) state_nx = S_LERP;
			S_LERP: begin
				if (lerp_vld && got_q == 3'd4) begin
					state_nx = sel_q ? S_EMIT : S_LDA;
				end
			end
			S_EMIT: begin
				if (slot_free && k_q == seq_len(case_q) - 1'b1) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			vcnt_q    <= '0;
			near_q    <= 32'd6554;
			out_vld_q <= 1'b0;
			sel_q     <= 1'b0;
			iss_q     <= '0;
			got_q     <= '0;
			k_q       <= '0;
			case_q    <= CC_NONE;
		end else begin
			state_q <= state_nx;
			if (cfg_wr_en) begin
				near_q <= cfg_wr_data;
			end
			if (in_fire) begin
				vcnt_q <= (vcnt_q == 2'd2) ? 2'd0 : vcnt_q + 1'b1;
				if (vcnt_q == 2'd2) begin
					case_q <= case_nx;
					sel_q  <= 1'b0;
					k_q    <= '0;
				end
			end
			if (state_q == S_DIV) begin
				iss_q <= '0;
				got_q <= '0;
			end
			if (state_q == S_LERP) begin
				if (iss_q < 3'd5) begin
					iss_q <= iss_q + 1'b1;
				end
				if (lerp_vld) begin
					got_q <= got_q + 1'b1;
					if (got_q == 3'd4) begin
						sel_q <= 1'b1;
					end
				end
			end
			if (state_q == S_EMIT && slot_free) begin
				out_vld_q <= 1'b1;
				k_q       <= k_q + 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			vx_q[vcnt_q] <= in_x;
			vy_q[vcnt_q] <= in_y;
			vz_q[vcnt_q] <= in_z;
			vr_q[vcnt_q] <= in_r;
			vg_q[vcnt_q] <= in_g;
			vb_q[vcnt_q] <= in_b;
			if (vcnt_q == 2'd2) begin
				near_s_q <= near_q;
			end
		end
		if (state_q == S_LDA) begin
			a_z_q  <= rz;
			a_q[0] <= $signed({rx[31], rx});
			a_q[1] <= $signed({ry[31], ry});
			a_q[2] <= $signed({17'd0, rr});
			a_q[3] <= $signed({17'd0, rg});
			a_q[4] <= $signed({17'd0, rb});
		end
		if (state_q == S_LDB) begin
			b_q[0] <= $signed({rx[31], rx});
			b_q[1] <= $signed({ry[31], ry});
			b_q[2] <= $signed({17'd0, rr});
			b_q[3] <= $signed({17'd0, rg});
			b_q[4] <= $signed({17'd0, rb});
		end
		if (state_q == S_LERP && lerp_vld) begin
			unique case (got_q)
				3'd0:    cx_q[sel_q] <= lerp_res[COORD_W-1:0];
				3'd1:    cy_q[sel_q] <= lerp_res[COORD_W-1:0];
				3'd2:    cr_q[sel_q] <= lerp_res[COLOUR_W-1:0];
				3'd3:    cg_q[sel_q] <= lerp_res[COLOUR_W-1:0];
				default: cb_q[sel_q] <= lerp_res[COLOUR_W-1:0];
			endcase
		end
		if (state_q == S_EMIT && slot_free) begin
			out_data_q   <= {eb, eg, er, ez, ey, ex};
			out_corner_q <= (k_q >= 3'd3) ? 2'(k_q - 3'd3) : k_q[1:0];
			out_last_q   <= (k_q == seq_len(case_q) - 1'b1);
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_corner_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
	a_vcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q != 2'd3)
		else $error("vertex count out of range");
	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (k_q < seq_len(case_q)))
		else $error("emission index past sequence end");
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside divide state");
	a_lerp_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LERP && lerp_vld) |-> (got_q < iss_q))
		else $error("lerp result without issue");
`endif

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import nptc_pkg::*;

	localparam int FRAC = 16;
	localparam int SETTLE_CYCLES = 100;

	typedef struct {
		longint p[3];
		longint c[3];
	} vert_t;

	typedef struct {
		logic [TDATA_W-1:0] data;
		logic [1:0]         corner;
		logic               last;
	} vbeat_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [31:0]         cfg_wr_data;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [TDATA_W-1:0]  s_axis_tdata;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [TDATA_W-1:0]  m_axis_tdata;
	logic [1:0]          m_axis_tuser;
	logic                m_axis_tlast;

	vbeat_t             expected_vertices[$];
	logic [TDATA_W-1:0] held_beats[3];
	int                 held_count;
	logic [31:0]        near_reg;
	int                 mismatches;
	int                 tx_idle_pct;
	int                 rx_idle_pct;
	logic [TDATA_W-1:0] directed[24];

	near_plane_triangle_clipper_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [TDATA_W-1:0] mk_vertex(logic [31:0] x, logic [31:0] y,
			logic [31:0] z, logic [15:0] r, logic [15:0] g, logic [15:0] b);
		return {b, g, r, z, y, x};
	endfunction

	function automatic vert_t unpack_vertex(logic [TDATA_W-1:0] d);
		vert_t v;
		for (int i = 0; i < 3; i++) begin
			v.p[i] = longint'($signed(d[32*i +: 32]));
			v.c[i] = longint'(d[96 + 16*i +: 16]);
		end
		return v;
	endfunction

	function automatic longint lerp_toward(longint a, longint b, longint r);
		longint d;
		longint m;
		longint q;
		d = b - a;
		m = (d < 0) ? -d : d;
		q = (m * r) >>> FRAC;
		return (d < 0) ? a - q : a + q;
	endfunction

	function automatic vert_t cut_edge(vert_t a, vert_t b, longint zn);
		vert_t v;
		longint num;
		longint den;
		longint r;
		num = zn - a.p[2];
		den = b.p[2] - a.p[2];
		r = (den != 0) ? ((num <<< FRAC) / den) : 0;
		if (r > (longint'(1) <<< FRAC))
			r = longint'(1) <<< FRAC;
		v.p[0] = lerp_toward(a.p[0], b.p[0], r);
		v.p[1] = lerp_toward(a.p[1], b.p[1], r);
		v.p[2] = zn;
		for (int i = 0; i < 3; i++)
			v.c[i] = lerp_toward(a.c[i], b.c[i], r);
		return v;
	endfunction

	task automatic push_triangle(vert_t a, vert_t b, vert_t c, bit fin);
		vert_t  t[3];
		vbeat_t e;
		t[0] = a;
		t[1] = b;
		t[2] = c;
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				e.data[32*i +: 32]      = t[k].p[i][31:0];
				e.data[96 + 16*i +: 16] = t[k].c[i][15:0];
			end
			e.corner = k[1:0];
			e.last   = fin && (k == 2);
			expected_vertices.push_back(e);
		end
	endtask

	task automatic clip_vertex(logic [TDATA_W-1:0] d);
		vert_t  v[3];
		vert_t  pa;
		vert_t  pb;
		bit     bh[3];
		longint zn;
		held_beats[held_count] = d;
		if (held_count < 2) begin
			held_count++;
			return;
		end
		held_count = 0;
		zn = longint'($signed(near_reg));
		for (int k = 0; k < 3; k++) begin
			v[k]  = unpack_vertex(held_beats[k]);
			bh[k] = v[k].p[2] < zn;
		end
		if (bh[0] && bh[1] && bh[2])
			return;
		if (!bh[0] && !bh[1] && !bh[2]) begin
			push_triangle(v[0], v[1], v[2], 1'b1);
		end else if (bh[0] && bh[1]) begin
			push_triangle(cut_edge(v[0], v[2], zn), v[2], cut_edge(v[1], v[2], zn), 1'b1);
		end else if (bh[0] && bh[2]) begin
			push_triangle(cut_edge(v[0], v[1], zn), v[1], cut_edge(v[2], v[1], zn), 1'b1);
		end else if (bh[1] && bh[2]) begin
			push_triangle(cut_edge(v[1], v[0], zn), v[0], cut_edge(v[2], v[0], zn), 1'b1);
		end else if (bh[0]) begin
			pa = cut_edge(v[0], v[1], zn);
			pb = cut_edge(v[0], v[2], zn);
			push_triangle(pa, pb, v[2], 1'b0);
			push_triangle(v[1], pa, v[2], 1'b1);
		end else if (bh[1]) begin
			pa = cut_edge(v[1], v[0], zn);
			pb = cut_edge(v[1], v[2], zn);
			push_triangle(pa, pb, v[2], 1'b0);
			push_triangle(v[0], pa, v[2], 1'b1);
		end else begin
			pa = cut_edge(v[2], v[0], zn);
			pb = cut_edge(v[2], v[1], zn);
			push_triangle(pa, pb, v[1], 1'b0);
			push_triangle(v[0], pa, v[1], 1'b1);
		end
	endtask

	task automatic send_vertex(logic [TDATA_W-1:0] d);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = d;
		do
			@(posedge clk);
		while (!s_axis_tready);
		clip_vertex(d);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic write_near(logic [31:0] value);
		while (expected_vertices.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(posedge clk);
		near_reg = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	function automatic logic [TDATA_W-1:0] random_vertex();
		longint z;
		if ($urandom_range(3) == 0) begin
			z = longint'($signed($urandom()));
		end else begin
			z = longint'($signed(near_reg)) + $signed($urandom_range(2097152)) - 1048576;
			if (z > 64'sd2147483647)
				z = 64'sd2147483647;
			if (z < -64'sd2147483648)
				z = -64'sd2147483648;
		end
		return mk_vertex($urandom(), $urandom(), z[31:0], 16'($urandom()),
			16'($urandom()), 16'($urandom()));
	endfunction

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_vertices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: data=%h corner=%0d last=%b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
			end else begin
				if (m_axis_tdata !== expected_vertices[0].data
						|| m_axis_tuser !== expected_vertices[0].corner
						|| m_axis_tlast !== expected_vertices[0].last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat mismatch: exp %h/%0d/%b got %h/%0d/%b",
							expected_vertices[0].data, expected_vertices[0].corner,
							expected_vertices[0].last, m_axis_tdata, m_axis_tuser,
							m_axis_tlast);
				end
				void'(expected_vertices.pop_front());
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic [31:0] nears[6];
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		mismatches    = 0;
		held_count    = 0;
		near_reg      = 32'd6554;
		tx_idle_pct   = 15;
		rx_idle_pct   = 74;

		// near plane at 6554; front z 0x20000, behind z -0x20000
		directed = '{
			mk_vertex(32'h7fffffff, 32'h80000000, 32'h00020000, 16'hffff, 16'h0000, 16'hffff),
			mk_vertex(32'h80000000, 32'h7fffffff, 32'h00001999, 16'h0000, 16'hffff, 16'h0000),
			mk_vertex(32'h00000000, 32'hffffffff, 32'h7fffffff, 16'h1234, 16'h5678, 16'h9abc),
			mk_vertex(32'h00010000, 32'h00020000, 32'hfffe0000, 16'h0100, 16'h0200, 16'h0300),
			mk_vertex(32'hffff0000, 32'h00030000, 32'hfff00000, 16'hff00, 16'h00ff, 16'h0f0f),
			mk_vertex(32'h00050000, 32'hfffb0000, 32'h00040000, 16'h8000, 16'h4000, 16'h2000),
			mk_vertex(32'h00010000, 32'h00010000, 32'hffff0000, 16'h0000, 16'hffff, 16'h1111),
			mk_vertex(32'h7fffffff, 32'h80000000, 32'h00030000, 16'hffff, 16'h0000, 16'h2222),
			mk_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, 16'h0001, 16'h8000, 16'h3333),
			mk_vertex(32'h00020000, 32'h00020000, 32'h00020000, 16'h1000, 16'h2000, 16'h3000),
			mk_vertex(32'hfffe0000, 32'h00000000, 32'hfff80000, 16'h4000, 16'h5000, 16'h6000),
			mk_vertex(32'h00000000, 32'hfffe0000, 32'hfffc0000, 16'h7000, 16'h8000, 16'h9000),
			mk_vertex(32'h80000000, 32'h12345678, 32'h80000000, 16'hffff, 16'hffff, 16'hffff),
			mk_vertex(32'h7fffffff, 32'h87654321, 32'h7fffffff, 16'h0000, 16'h0000, 16'h0000),
			mk_vertex(32'h00001000, 32'hfffff000, 32'h0000199a, 16'h0abc, 16'h0def, 16'h0123),
			mk_vertex(32'h00100000, 32'h00200000, 32'h00010000, 16'h0100, 16'h0100, 16'h0100),
			mk_vertex(32'hfff00000, 32'hffe00000, 32'hffff8000, 16'hff00, 16'hff00, 16'hff00),
			mk_vertex(32'h00000000, 32'h00000000, 32'h00050000, 16'h8080, 16'h8080, 16'h8080),
			mk_vertex(32'h00030000, 32'h00040000, 32'h00010000, 16'h0001, 16'h0002, 16'h0003),
			mk_vertex(32'h00050000, 32'h00060000, 32'h00020000, 16'h0004, 16'h0005, 16'h0006),
			mk_vertex(32'h00070000, 32'h00080000, 32'hffff0000, 16'h0007, 16'h0008, 16'h0009),
			mk_vertex(32'h00010000, 32'h00010000, 32'hfffe0000, 16'hffff, 16'hffff, 16'hffff),
			mk_vertex(32'h00020000, 32'h00020000, 32'h00000000, 16'h0000, 16'h0000, 16'h0000),
			mk_vertex(32'h00030000, 32'h00030000, 32'h80000000, 16'h1234, 16'h1234, 16'h1234)
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i])
			send_vertex(directed[i]);

		nears = '{32'h00000000, 32'h80000000, 32'h7fffffff, $urandom(), 32'hfffff000, 32'd6554};
		for (int ph = 0; ph < 6; ph++) begin
			write_near(nears[ph]);
			case (ph / 2)
				0: begin tx_idle_pct = 15; rx_idle_pct = 74; end
				1: begin tx_idle_pct = 74; rx_idle_pct = 15; end
				default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
			endcase
			for (int t = 0; t < 42; t++)
				send_vertex(random_vertex());
		end

		while (expected_vertices.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> near_plane_triangle_clipper_unit.f
rtl/nptc_pkg.sv
rtl/nptc_div.sv
rtl/nptc_lerp.sv
rtl/near_plane_triangle_clipper_unit.sv
sim/tb_top.sv
